// ===== hw/rtl/ilsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the interrupt line share allocator.
// No dependencies; ilsa_upd, the top, ilsa_chk and the testbench import it.
package ilsa_pkg;

    localparam int NUM_LINES   = 16;
    localparam int COUNT_WIDTH = 8;
    localparam int LINE_W      = 5;
    localparam int IDX_W       = $clog2(NUM_LINES);
    localparam int SHARE_W     = 8;

    typedef enum logic [1:0] {
        OP_CLAIM   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADD     = 2'd2,
        OP_REMOVE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SH_EXCL = 2'd0,
        SH_TIME = 2'd1,
        SH_DYN  = 2'd2,
        SH_NONE = 2'd3
    } t_share;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IN_USE   = 2'd1,
        ST_BAD_ATTR = 2'd2,
        ST_BAD_LINE = 2'd3
    } t_status;

    // Line type codes held in the table entry
    localparam logic [1:0] LT_NONE = 2'd0;
    localparam logic [1:0] LT_TIME = 2'd1;
    localparam logic [1:0] LT_DYN  = 2'd2;

    typedef struct packed {
        logic [1:0]             typ;
        logic                   removed;
        logic                   resv;
        logic                   alloc;
        logic [COUNT_WIDTH-1:0] tcnt;
        logic [COUNT_WIDTH-1:0] dcnt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_op    op;
        t_share share;
        logic   first_sharer;
        logic   specific;
        logic   host_line_free;
        logic   want_reserved;
        logic   claims_allocated;
    } t_req;

    typedef struct packed {
        t_status status;
        t_entry  entry;
    } t_upd;

    // Share count shown for a line: counter chosen by type, clamped to 8 bits
    function automatic logic [SHARE_W-1:0] share_of(input t_entry e);
        logic [15:0] ext;
        ext = '0;
        if (e.typ == LT_TIME) begin
            ext = 16'(e.tcnt);
        end else if (e.typ == LT_DYN) begin
            ext = 16'(e.dcnt);
        end
        share_of = (ext > 16'd255) ? 8'hFF : ext[7:0];
    endfunction

endpackage

// ===== hw/rtl/ilsa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ilsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ilsa_upd.sv =====
`timescale 1ns / 1ps
// Entry update logic: applies one operation to one table entry.
// Depends on ilsa_pkg.
module ilsa_upd import ilsa_pkg::*; (
    input  t_req   i_req,
    input  t_entry i_entry,
    output t_upd   o_upd
);

    t_entry  e;
    t_status st;
    logic [1:0] want_typ;

    always_comb begin
        e        = i_entry;
        st       = ST_OK;
        want_typ = 2'(i_req.share);
        case (i_req.op)
            OP_CLAIM: begin
                if (i_entry.alloc) begin
                    if (i_req.share == SH_EXCL) begin
                        st = ST_IN_USE;
                    end else if (i_req.share == SH_NONE) begin
                        st = ST_OK;
                    end else if (i_entry.typ != want_typ) begin
                        st = ST_IN_USE;
                    end else if (i_req.first_sharer) begin
                        st = ST_BAD_ATTR;
                    end else if (i_req.share == SH_TIME) begin
                        if (i_entry.tcnt != '1) e.tcnt = i_entry.tcnt + 1'b1;
                    end else begin
                        if (i_entry.dcnt != '1) e.dcnt = i_entry.dcnt + 1'b1;
                    end
                end else if (i_entry.resv && !i_req.specific) begin
                    st = ST_IN_USE;
                end else if (!i_req.host_line_free) begin
                    st = ST_IN_USE;
                end else if (i_req.share == SH_EXCL) begin
                    e.alloc = 1'b1;
                end else if (i_req.share != SH_NONE) begin
                    if (!i_req.first_sharer) begin
                        st = ST_BAD_ATTR;
                    end else begin
                        e.alloc = 1'b1;
                        e.typ   = want_typ;
                        if (i_req.share == SH_TIME) begin
                            e.tcnt = COUNT_WIDTH'(1);
                        end else begin
                            e.dcnt = COUNT_WIDTH'(1);
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (i_req.share == SH_EXCL) begin
                    e.alloc   = 1'b0;
                    e.removed = 1'b0;
                    e.typ     = LT_NONE;
                end else if (i_req.share == SH_TIME) begin
                    if (i_entry.tcnt != '0) e.tcnt = i_entry.tcnt - 1'b1;
                    if (e.tcnt == '0) begin
                        e.alloc   = 1'b0;
                        e.removed = 1'b0;
                        e.typ     = LT_NONE;
                    end
                end else if (i_req.share == SH_DYN) begin
                    if (i_entry.dcnt != '0) e.dcnt = i_entry.dcnt - 1'b1;
                    if (e.dcnt == '0) begin
                        e.alloc   = 1'b0;
                        e.removed = 1'b0;
                        e.typ     = LT_NONE;
                    end
                end
            end
            OP_ADD: begin
                if (i_entry.removed) begin
                    e.removed = 1'b0;
                    e.alloc   = 1'b0;
                    e.resv    = i_req.want_reserved;
                end else if (i_req.claims_allocated) begin
                    st = ST_IN_USE;
                end else begin
                    e.resv = i_req.want_reserved;
                end
            end
            OP_REMOVE: begin
                if (i_entry.removed) begin
                    st = ST_OK;
                end else if (i_entry.alloc) begin
                    st = ST_IN_USE;
                end else begin
                    e.alloc   = 1'b1;
                    e.removed = 1'b1;
                    e.resv    = 1'b0;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
        o_upd.status = st;
        o_upd.entry  = e;
    end

endmodule

// ===== hw/rtl/interrupt_line_share_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the interrupt line share allocator: line table RAM, valid bits,
// sequencer and output register. Depends on ilsa_pkg, ilsa_ram, ilsa_upd.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall    | opcode, line, share_type, flags
//   out     | output    | o_out_valid / i_out_stall  | status, line_allocated, count
//
// For each item the accept edge issues the table read; once the output register
// can take the result, a later edge writes the updated entry back and loads the
// output register. The registered read data of the line table RAM sets this split.
// Reset clears the per-line valid bits; no clearing pass runs, a line never
// written reads as all zero.
// A result waiting in the output register does not block a new item; the
// write-back step waits only while the output register is full and stalled.
module interrupt_line_share_allocator import ilsa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [LINE_W-1:0]  i_line,
    input  logic [1:0]         i_share_type,
    input  logic               i_first_sharer,
    input  logic               i_specific,
    input  logic               i_host_line_free,
    input  logic               i_want_reserved,
    input  logic               i_claims_allocated,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_line_allocated,
    output logic [SHARE_W-1:0] o_share_count
);

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    t_state             r_state;
    t_req               r_req;
    logic [IDX_W-1:0]   r_idx;
    logic               r_bad;
    logic [NUM_LINES-1:0] r_vld;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic               r_line_alloc;
    logic [SHARE_W-1:0] r_share;

    logic               accept;
    logic               done;
    logic               taken;
    logic               in_bad;
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_data;
    t_entry             cur_entry;
    t_upd               upd;
    t_req               in_req;

    // One item in flight; hold the input while it is worked on
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign taken      = r_out_valid && !i_out_stall;
    // Advance to write-back once the output register can take the result
    assign done       = (r_state == S_WORK) && (!r_out_valid || !i_out_stall);
    assign in_bad     = ({1'b0, i_line} >= (LINE_W + 1)'(NUM_LINES));
    assign wr_en      = done && !r_bad;

    assign in_req.op               = t_op'(i_opcode);
    assign in_req.share            = t_share'(i_share_type);
    assign in_req.first_sharer     = i_first_sharer;
    assign in_req.specific         = i_specific;
    assign in_req.host_line_free   = i_host_line_free;
    assign in_req.want_reserved    = i_want_reserved;
    assign in_req.claims_allocated = i_claims_allocated;

    ilsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_LINES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx),
        .i_wdata (upd.entry),
        .i_re    (accept),
        .i_raddr (i_line[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // A line never written reads as its reset value
    assign cur_entry = r_vld[r_idx] ? t_entry'(rd_data) : '0;

    ilsa_upd u_upd (
        .i_req   (r_req),
        .i_entry (cur_entry),
        .o_upd   (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop a taken result unless a new one loads on the same edge
            if (taken && !done) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vld[r_idx] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_WORK;
                        r_req   <= in_req;
                        r_idx   <= i_line[IDX_W-1:0];
                        r_bad   <= in_bad;
                    end
                end
                S_WORK: begin
                    if (done) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (r_bad) begin
                            // Out-of-range line: fixed result, table untouched
                            r_status     <= ST_BAD_LINE;
                            r_line_alloc <= 1'b0;
                            r_share      <= '0;
                        end else begin
                            r_status     <= upd.status;
                            r_line_alloc <= upd.entry.alloc;
                            r_share      <= share_of(upd.entry);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_line_allocated = r_line_alloc;
    assign o_share_count    = r_share;

endmodule

// ===== hw/rtl/ilsa_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the interrupt line share allocator, bound to the top.
// Depends on ilsa_pkg.
module ilsa_chk import ilsa_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic               o_line_allocated,
    input logic [SHARE_W-1:0] o_share_count
);

    logic accept;
    assign accept = i_in_valid && !o_in_stall;

    // Drop any result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Hold one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second item taken while one is in flight");

    // Deliver the result in the cycle after the output register frees up
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept ##1 (!o_out_valid || !i_out_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    // Out-of-range lines report nothing allocated and no count
    a_bad_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BAD_LINE) |->
            (!o_line_allocated && o_share_count == '0))
        else $error("bad line result carries line data");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_line_allocated)
             && $stable(o_share_count)))
        else $error("stalled result changed");

endmodule

bind interrupt_line_share_allocator ilsa_chk u_ilsa_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_line_allocated (o_line_allocated),
    .o_share_count    (o_share_count)
);

// ===== verif/tb_interrupt_line_share_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for interrupt_line_share_allocator: directed table, a saturation
// run and random line operations, each result checked against a typed-in report or the model.
// Depends on ilsa_pkg and the RTL of interrupt_line_share_allocator.
module tb_interrupt_line_share_allocator;
    import ilsa_pkg::*;

    // One request as offered on the input channel
    typedef struct packed {
        t_op               op;
        logic [LINE_W-1:0] line;
        t_share            share;
        logic              first_sharer;
        logic              specific;
        logic              host_line_free;
        logic              want_reserved;
        logic              claims_allocated;
    } t_lreq;

    // One line report as seen on the output channel
    typedef struct packed {
        t_status            status;
        logic               allocated;
        logic [SHARE_W-1:0] count;
    } t_line_report;

    // Directed row: request, whether the report is typed in, and that report
    typedef struct packed {
        t_lreq        req;
        logic         typed;
        t_line_report want;
    } t_dir_row;

    localparam logic Y = 1'b1;
    localparam logic N = 1'b0;

    localparam int DIR_ROWS     = 25;
    localparam int SAT_CLAIMS   = 258;
    localparam int RAND_ITEMS   = 120;
    localparam int SAT_TIME_LN  = 5;
    localparam int HOLD_CYCLES  = 90;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 60000;

    // Columns: op, line, share, first, specific, host free, want reserved,
    //          claims allocated | typed | status, allocated, share count
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // lines past the table end
        '{'{OP_CLAIM,   5'd16, SH_EXCL, N, N, Y, N, N}, Y, '{ST_BAD_LINE, N, 8'd0}},
        '{'{OP_REMOVE,  5'd31, SH_NONE, Y, Y, Y, Y, Y}, Y, '{ST_BAD_LINE, N, 8'd0}},
        // exclusive use of line 0
        '{'{OP_RELEASE, 5'd0,  SH_NONE, N, N, N, N, N}, Y, '{ST_OK,       N, 8'd0}},
        '{'{OP_CLAIM,   5'd0,  SH_EXCL, N, N, N, N, N}, Y, '{ST_IN_USE,   N, 8'd0}},
        '{'{OP_CLAIM,   5'd0,  SH_EXCL, N, N, Y, N, N}, Y, '{ST_OK,       Y, 8'd0}},
        '{'{OP_CLAIM,   5'd0,  SH_EXCL, N, N, Y, N, N}, Y, '{ST_IN_USE,   Y, 8'd0}},
        '{'{OP_CLAIM,   5'd0,  SH_TIME, N, N, Y, N, N}, Y, '{ST_IN_USE,   Y, 8'd0}},
        '{'{OP_CLAIM,   5'd0,  SH_NONE, N, N, Y, N, N}, Y, '{ST_OK,       Y, 8'd0}},
        '{'{OP_RELEASE, 5'd0,  SH_EXCL, N, N, N, N, N}, Y, '{ST_OK,       N, 8'd0}},
        // time sharing on line 1, first-sharer rule, release down past zero
        '{'{OP_CLAIM,   5'd1,  SH_TIME, N, N, Y, N, N}, Y, '{ST_BAD_ATTR, N, 8'd0}},
        '{'{OP_CLAIM,   5'd1,  SH_TIME, Y, N, Y, N, N}, Y, '{ST_OK,       Y, 8'd1}},
        '{'{OP_CLAIM,   5'd1,  SH_TIME, Y, N, Y, N, N}, Y, '{ST_BAD_ATTR, Y, 8'd1}},
        '{'{OP_CLAIM,   5'd1,  SH_TIME, N, N, Y, N, N}, N, '{ST_OK,       N, 8'd0}},
        '{'{OP_CLAIM,   5'd1,  SH_DYN,  N, N, Y, N, N}, N, '{ST_OK,       N, 8'd0}},
        '{'{OP_RELEASE, 5'd1,  SH_TIME, N, N, N, N, N}, N, '{ST_OK,       N, 8'd0}},
        '{'{OP_RELEASE, 5'd1,  SH_TIME, N, N, N, N, N}, N, '{ST_OK,       N, 8'd0}},
        '{'{OP_RELEASE, 5'd1,  SH_TIME, N, N, N, N, N}, Y, '{ST_OK,       N, 8'd0}},
        // reserved mark and the specific override on line 2
        '{'{OP_ADD,     5'd2,  SH_NONE, N, N, N, Y, N}, Y, '{ST_OK,       N, 8'd0}},
        '{'{OP_CLAIM,   5'd2,  SH_EXCL, N, N, Y, N, N}, Y, '{ST_IN_USE,   N, 8'd0}},
        '{'{OP_CLAIM,   5'd2,  SH_DYN,  Y, Y, Y, N, N}, N, '{ST_OK,       N, 8'd0}},
        '{'{OP_REMOVE,  5'd2,  SH_NONE, N, N, N, N, N}, Y, '{ST_IN_USE,   Y, 8'd1}},
        // managed lines: remove twice, add back, add with a false allocated flag
        '{'{OP_REMOVE,  5'd15, SH_NONE, N, N, N, N, N}, Y, '{ST_OK,       Y, 8'd0}},
        '{'{OP_REMOVE,  5'd15, SH_NONE, N, N, N, N, N}, Y, '{ST_OK,       Y, 8'd0}},
        '{'{OP_ADD,     5'd15, SH_NONE, N, N, N, N, Y}, Y, '{ST_OK,       N, 8'd0}},
        '{'{OP_ADD,     5'd3,  SH_NONE, N, N, N, Y, Y}, Y, '{ST_IN_USE,   N, 8'd0}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic [LINE_W-1:0]  i_line;
    logic [1:0]         i_share_type;
    logic               i_first_sharer;
    logic               i_specific;
    logic               i_host_line_free;
    logic               i_want_reserved;
    logic               i_claims_allocated;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic               o_line_allocated;
    logic [SHARE_W-1:0] o_share_count;

    // Model copy of the line table and the reports still owed by the block
    t_entry       line_tab [NUM_LINES];
    t_line_report line_reports_due [$];

    int err_count     = 0;
    int reports_seen  = 0;
    int cycle_count   = 0;
    int hold_req      = 0;
    bit quiet         = 1'b0;

    always #4 i_clk = ~i_clk;

    interrupt_line_share_allocator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_line             (i_line),
        .i_share_type       (i_share_type),
        .i_first_sharer     (i_first_sharer),
        .i_specific         (i_specific),
        .i_host_line_free   (i_host_line_free),
        .i_want_reserved    (i_want_reserved),
        .i_claims_allocated (i_claims_allocated),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_line_allocated   (o_line_allocated),
        .o_share_count      (o_share_count)
    );

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at report %0d: %s got %0d want %0d", reports_seen, what, got, want);
    endtask

    // Apply one request to the model table and return the report it yields
    function automatic t_line_report predict_line_op(input t_lreq r);
        t_entry       e;
        t_status      st;
        t_line_report rep;
        int           cnt;
        int           idx;
        rep = '0;
        if (int'(r.line) >= NUM_LINES) begin
            rep.status = ST_BAD_LINE;
            return rep;
        end
        idx = int'(r.line);
        e   = line_tab[idx];
        st  = ST_OK;
        case (r.op)
            OP_CLAIM: begin
                if (e.alloc) begin
                    // held line: only a matching sharer may join
                    if (r.share == SH_EXCL) begin
                        st = ST_IN_USE;
                    end else if (r.share == SH_NONE) begin
                        st = ST_OK;
                    end else if (e.typ != 2'(r.share)) begin
                        st = ST_IN_USE;
                    end else if (r.first_sharer) begin
                        st = ST_BAD_ATTR;
                    end else if (r.share == SH_TIME) begin
                        if (e.tcnt != {COUNT_WIDTH{1'b1}}) e.tcnt = e.tcnt + 1'b1;
                    end else begin
                        if (e.dcnt != {COUNT_WIDTH{1'b1}}) e.dcnt = e.dcnt + 1'b1;
                    end
                end else if (e.resv && !r.specific) begin
                    st = ST_IN_USE;
                end else if (!r.host_line_free) begin
                    st = ST_IN_USE;
                end else if (r.share == SH_EXCL) begin
                    e.alloc = 1'b1;
                end else if (r.share != SH_NONE) begin
                    if (!r.first_sharer) begin
                        st = ST_BAD_ATTR;
                    end else begin
                        e.alloc = 1'b1;
                        if (r.share == SH_TIME) begin
                            e.typ  = LT_TIME;
                            e.tcnt = COUNT_WIDTH'(1);
                        end else begin
                            e.typ  = LT_DYN;
                            e.dcnt = COUNT_WIDTH'(1);
                        end
                    end
                end
            end
            OP_RELEASE: begin
                if (r.share == SH_EXCL) begin
                    e.alloc   = 1'b0;
                    e.removed = 1'b0;
                    e.typ     = LT_NONE;
                end else if (r.share != SH_NONE) begin
                    if (r.share == SH_TIME) begin
                        if (e.tcnt != '0) e.tcnt = e.tcnt - 1'b1;
                        cnt = int'(e.tcnt);
                    end else begin
                        if (e.dcnt != '0) e.dcnt = e.dcnt - 1'b1;
                        cnt = int'(e.dcnt);
                    end
                    if (cnt == 0) begin
                        e.alloc   = 1'b0;
                        e.removed = 1'b0;
                        e.typ     = LT_NONE;
                    end
                end
            end
            OP_ADD: begin
                if (e.removed) begin
                    e.removed = 1'b0;
                    e.alloc   = 1'b0;
                end else if (r.claims_allocated) begin
                    st = ST_IN_USE;
                end
                if (st == ST_OK) e.resv = r.want_reserved;
            end
            default: begin
                if (e.removed) begin
                    st = ST_OK;
                end else if (e.alloc) begin
                    st = ST_IN_USE;
                end else begin
                    e.alloc   = 1'b1;
                    e.removed = 1'b1;
                    e.resv    = 1'b0;
                end
            end
        endcase
        line_tab[idx] = e;
        cnt = 0;
        if (e.typ == LT_TIME) begin
            cnt = int'(e.tcnt);
        end else if (e.typ == LT_DYN) begin
            cnt = int'(e.dcnt);
        end
        rep.status    = st;
        rep.allocated = e.alloc;
        rep.count     = (cnt > 255) ? 8'hFF : 8'(cnt);
        return rep;
    endfunction

    // Offer one item after a drawn gap, hold it until accepted, then log the
    // report it owes: the typed-in one if given, else the model's
    task automatic offer_line_op(input t_lreq r, input logic typed, input t_line_report fixed);
        int           gap;
        t_line_report calc;
        gap = quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode           <= r.op;
        i_line             <= r.line;
        i_share_type       <= r.share;
        i_first_sharer     <= r.first_sharer;
        i_specific         <= r.specific;
        i_host_line_free   <= r.host_line_free;
        i_want_reserved    <= r.want_reserved;
        i_claims_allocated <= r.claims_allocated;
        i_in_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        calc = predict_line_op(r);
        line_reports_due.push_back(typed ? fixed : calc);
    endtask

    // Receiver: stall a drawn number of cycles per report; a hold request from
    // the stimulus turns into one long stall counted here
    initial begin : out_side
        int n;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 15);
            end
            @(negedge i_clk);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Check each accepted report against the oldest one owed
    always @(posedge i_clk) begin : report_check
        t_line_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            if (line_reports_due.size() == 0) begin
                report_mismatch("report with nothing owed, status", int'(o_status), -1);
            end else begin
                want = line_reports_due.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_line_allocated != want.allocated)
                    report_mismatch("line_allocated", int'(o_line_allocated),
                                    int'(want.allocated));
                if (o_share_count != want.count)
                    report_mismatch("share_count", int'(o_share_count), int'(want.count));
            end
        end
    end

    // Watchdog: drop the run if it goes far past the slowest correct run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_lreq r;
        int    k;
        int    pick;
        logic  busy;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_opcode           = '0;
        i_line             = '0;
        i_share_type       = '0;
        i_first_sharer     = 1'b0;
        i_specific         = 1'b0;
        i_host_line_free   = 1'b0;
        i_want_reserved    = 1'b0;
        i_claims_allocated = 1'b0;
        foreach (line_tab[j]) line_tab[j] = '0;

        // Hold reset, then release it away from the sampling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (k = 0; k < DIR_ROWS; k++) begin
            offer_line_op(DIR_TAB[k].req, DIR_TAB[k].typed, DIR_TAB[k].want);
        end

        // Open a time-shared line, then pile sharers onto it until the
        // counter pins at its maximum; the first stretch runs back to back
        // on both sides
        r = '0;
        r.op             = OP_CLAIM;
        r.first_sharer   = 1'b1;
        r.host_line_free = 1'b1;
        r.line           = LINE_W'(SAT_TIME_LN);
        r.share          = SH_TIME;
        offer_line_op(r, 1'b0, '0);
        for (k = 0; k < SAT_CLAIMS; k++) begin
            quiet              = (k < 100);
            r.op               = OP_CLAIM;
            r.line             = LINE_W'(SAT_TIME_LN);
            r.share            = SH_TIME;
            r.first_sharer     = 1'b0;
            r.specific         = 1'($urandom_range(0, 1));
            r.host_line_free   = 1'($urandom_range(0, 1));
            r.want_reserved    = 1'($urandom_range(0, 1));
            r.claims_allocated = 1'($urandom_range(0, 1));
            offer_line_op(r, 1'b0, '0);
        end

        // Random part: mostly a few hot lines so claims, shares and releases
        // interact; first_sharer follows the line state most of the time
        for (k = 0; k < RAND_ITEMS; k++) begin
            quiet = (k >= 40 && k < 80);
            // Stall the receiver for a long stretch while items keep coming
            if (k == 50) hold_req = HOLD_CYCLES;
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                r.line = LINE_W'($urandom_range(0, 7));
            end else if (pick < 95) begin
                r.line = LINE_W'($urandom_range(8, NUM_LINES - 1));
            end else begin
                r.line = LINE_W'($urandom_range(NUM_LINES, 31));
            end
            pick = $urandom_range(0, 99);
            r.op = (pick < 45) ? OP_CLAIM : (pick < 75) ? OP_RELEASE :
                   (pick < 87) ? OP_ADD : OP_REMOVE;
            r.share = ($urandom_range(0, 9) == 0) ? SH_NONE : t_share'($urandom_range(0, 2));
            busy = (int'(r.line) < NUM_LINES) && line_tab[r.line[IDX_W-1:0]].alloc;
            r.first_sharer     = ($urandom_range(0, 99) < 85) ? !busy : busy;
            r.specific         = 1'($urandom_range(0, 1));
            r.host_line_free   = ($urandom_range(0, 9) != 0);
            r.want_reserved    = 1'($urandom_range(0, 1));
            r.claims_allocated = ($urandom_range(0, 9) < 3);
            offer_line_op(r, 1'b0, '0);
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain: wait for every owed report, then wait DRAIN_CYCLES more for strays
        while (line_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && line_reports_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ilsa_pkg.sv
hw/rtl/ilsa_ram.sv
hw/rtl/ilsa_upd.sv
hw/rtl/interrupt_line_share_allocator.sv
hw/rtl/ilsa_chk.sv
verif/tb_interrupt_line_share_allocator.sv
